// File: hw/rtl/gbfs_pkg.sv
package gbfs_pkg;

    // Graph size and field widths
    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = 4;
    localparam int HEUR_W       = 16;
    localparam int COST_W       = 10;
    localparam int KIND_W       = 2;
    localparam int VCOUNT_W     = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;

    // Edge cost that removes an edge
    localparam logic [COST_W-1:0] NO_EDGE_COST = COST_W'(999);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SET_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_HEUR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_VERTEX = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_EXPAND = 3'b100
    } state_t;

    // Control of the shared minimum-search unit
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

endpackage

// File: hw/rtl/gbfs_scan.sv
module gbfs_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbfs_pkg::scan_ctrl_t          ctrl,
    input  logic                          cand_valid,
    input  logic [gbfs_pkg::VIDX_W-1:0]   cand_index,
    input  logic [gbfs_pkg::HEUR_W-1:0]   cand_h,
    output logic [gbfs_pkg::VIDX_W-1:0]   best_index
);
    import gbfs_pkg::*;

    logic              have_reg;
    logic              have_next;
    logic [VIDX_W-1:0] best_index_reg;
    logic [HEUR_W-1:0] best_h_reg;
    logic              take;

    // Take a candidate only when strictly better, so ties keep the lower index
    assign take = cand_valid && (!have_reg || (cand_h < best_h_reg));

    always_comb
    begin
        have_next = have_reg;
        if (ctrl.clear)
        begin
            have_next = 1'b0;
        end
        else if (ctrl.step && take)
        begin
            have_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    // Hold the best candidate seen so far
    always_ff @(posedge clk)
    begin
        if (!ctrl.clear && ctrl.step && take)
        begin
            best_index_reg <= cand_index;
            best_h_reg     <= cand_h;
        end
    end

    assign best_index = best_index_reg;

endmodule

// File: hw/rtl/greedy_best_first_search.sv
// Channel  | Ports                                         | Handshake
// request  | kind first_vertex second_vertex edge_cost     | start & !busy
//          | heuristic_value                               |
// result   | expanded_vertex last_flag target_found        | result_valid, one cycle
// config   | cfg_index cfg_data                            | cfg_write
//
// A load request never makes the block busy. A run request scans, per expansion,
// every vertex in use and then takes an expand step; the single heuristic comparator
// in gbfs_scan is why the scan visits the vertices one at a time. Each result strobes
// in the cycle after its expand step; busy drops with the last. Reset at once clears
// the graph, heuristics, visited and frontier masks, sets the live mask, and loads
// vertex_count = 16, target_vertex = 0. The receiver cannot stall results.
module greedy_best_first_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gbfs_pkg::KIND_W-1:0]       kind,
    input  logic [gbfs_pkg::VIDX_W-1:0]       first_vertex,
    input  logic [gbfs_pkg::VIDX_W-1:0]       second_vertex,
    input  logic [gbfs_pkg::COST_W-1:0]       edge_cost,
    input  logic [gbfs_pkg::HEUR_W-1:0]       heuristic_value,
    output logic                              result_valid,
    output logic [gbfs_pkg::VIDX_W-1:0]       expanded_vertex,
    output logic                              last_flag,
    output logic                              target_found,
    input  logic                              cfg_write,
    input  logic [gbfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gbfs_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [HEUR_W-1:0]       heur_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] visited_next;
    logic [MAX_VERTICES-1:0] frontier_reg;
    logic [MAX_VERTICES-1:0] frontier_next;
    logic [MAX_VERTICES-1:0] live_reg;
    logic [MAX_VERTICES-1:0] live_next;
    logic [VIDX_W-1:0]       last_idx_reg;
    logic [VIDX_W-1:0]       last_idx_next;
    logic [VIDX_W-1:0]       idx_reg;
    logic [VIDX_W-1:0]       idx_next;
    logic [VCOUNT_W-1:0]     vcount_reg;
    logic [VIDX_W-1:0]       target_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [VIDX_W-1:0]       expanded_reg;
    logic                    last_reg;
    logic                    found_reg;
    logic [VCOUNT_W-1:0]     n_clamped;
    logic                    accept;
    logic                    exp_found;
    logic                    exp_last;
    logic [MAX_VERTICES-1:0] exp_visited;
    logic [MAX_VERTICES-1:0] exp_frontier;
    logic [VIDX_W-1:0]       best_index;
    scan_ctrl_t              scan_ctrl;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Clamp the vertex count into 1..MAX_VERTICES
    always_comb
    begin
        priority if (vcount_reg == '0)
        begin
            n_clamped = VCOUNT_W'(1);
        end
        else if (vcount_reg > VCOUNT_W'(MAX_VERTICES))
        begin
            n_clamped = VCOUNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_clamped = vcount_reg;
        end
    end

    // Build the live mask for the vertices in use
    always_comb
    begin
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            live_next[v] = (VCOUNT_W'(v) < n_clamped);
        end
        last_idx_next = VIDX_W'(n_clamped - VCOUNT_W'(1));
    end

    // Work out the expansion of the chosen vertex
    always_comb
    begin
        exp_visited  = visited_reg | (MAX_VERTICES'(1) << best_index);
        exp_frontier = (frontier_reg | (adj_reg[best_index] & live_reg)) & ~exp_visited;
        exp_found    = (best_index == target_reg);
        exp_last     = exp_found || (exp_frontier == '0);
    end

    // Sequence scan and expand steps
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        visited_next      = visited_reg;
        frontier_next     = frontier_reg;
        result_valid_next = 1'b0;
        scan_ctrl.clear   = 1'b0;
        scan_ctrl.step    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_RUN))
                begin
                    visited_next    = '0;
                    frontier_next   = MAX_VERTICES'(1);
                    idx_next        = '0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_EXPAND;
                end
                else
                begin
                    idx_next = idx_reg + VIDX_W'(1);
                end
            end
            ST_EXPAND:
            begin
                result_valid_next = 1'b1;
                visited_next      = exp_visited;
                frontier_next     = exp_found ? '0 : exp_frontier;
                idx_next          = '0;
                scan_ctrl.clear   = 1'b1;
                state_next        = exp_last ? ST_IDLE : ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control, masks, graph and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            visited_reg      <= '0;
            frontier_reg     <= '0;
            live_reg         <= '1;
            last_idx_reg     <= VIDX_W'(MAX_VERTICES - 1);
            result_valid_reg <= 1'b0;
            vcount_reg       <= VCOUNT_W'(MAX_VERTICES);
            target_reg       <= '0;
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                adj_reg[r]  <= '0;
                heur_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            visited_reg      <= visited_next;
            frontier_reg     <= frontier_next;
            result_valid_reg <= result_valid_next;
            if (accept && (kind == KIND_RUN))
            begin
                live_reg     <= live_next;
                last_idx_reg <= last_idx_next;
            end
            // Add or drop a symmetric edge
            if (accept && (kind == KIND_SET_EDGE))
            begin
                for (int r = 0; r < MAX_VERTICES; r++)
                begin
                    if (VIDX_W'(r) == first_vertex)
                    begin
                        adj_reg[r][second_vertex] <= (edge_cost != NO_EDGE_COST);
                    end
                    else if (VIDX_W'(r) == second_vertex)
                    begin
                        adj_reg[r][first_vertex] <= (edge_cost != NO_EDGE_COST);
                    end
                end
            end
            if (accept && (kind == KIND_SET_HEUR))
            begin
                heur_reg[first_vertex] <= heuristic_value;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_VERTEX_COUNT:  vcount_reg <= cfg_data;
                    CFG_TARGET_VERTEX: target_reg <= cfg_data[VIDX_W-1:0];
                    default:           vcount_reg <= vcount_reg;
                endcase
            end
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
        begin
            expanded_reg <= best_index;
            last_reg     <= exp_last;
            found_reg    <= exp_found;
        end
    end

    gbfs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .cand_valid (frontier_reg[idx_reg]),
        .cand_index (idx_reg),
        .cand_h     (heur_reg[idx_reg]),
        .best_index (best_index)
    );

    assign result_valid    = result_valid_reg;
    assign expanded_vertex = expanded_reg;
    assign last_flag       = last_reg;
    assign target_found    = found_reg;

`ifndef SYNTHESIS
    a_strobe_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EXPAND))
        else $error("result strobe without an expand step");
    a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last_flag))
        else $error("search ended without a last result");
    a_found_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && target_found) |-> last_flag)
        else $error("target found on a result not marked last");
    a_scan_has_frontier: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (frontier_reg != '0))
        else $error("scan with an empty frontier");
    a_visited_not_frontier: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((frontier_reg & visited_reg) == '0))
        else $error("visited vertex still on the frontier");
`endif

endmodule

// File: tb/sv/gbfs_checker.sv
module gbfs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [gbfs_pkg::KIND_W-1:0]       kind,
    input  logic [gbfs_pkg::VIDX_W-1:0]       first_vertex,
    input  logic [gbfs_pkg::VIDX_W-1:0]       second_vertex,
    input  logic [gbfs_pkg::COST_W-1:0]       edge_cost,
    input  logic [gbfs_pkg::HEUR_W-1:0]       heuristic_value,
    input  logic                              result_valid,
    input  logic [gbfs_pkg::VIDX_W-1:0]       expanded_vertex,
    input  logic                              last_flag,
    input  logic                              target_found,
    input  logic                              cfg_write,
    input  logic [gbfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatch_count,
    output int                                steps_pending,
    output int                                steps_checked
);
    import gbfs_pkg::*;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex;
        logic              last;
        logic              found;
    } expansion_t;

    // Shadow copy of the graph and the configuration
    logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
    logic [HEUR_W-1:0]       heuristics [MAX_VERTICES];
    logic [VCOUNT_W-1:0]     vertex_count_q;
    logic [VIDX_W-1:0]       target_q;

    expansion_t expected_steps [$];
    expansion_t got_step;
    expansion_t want_step;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("error at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Run one greedy search on the shadow graph and queue every expansion
    function automatic void search_expansions();
        int                      n;
        int                      count;
        int                      best;
        bit                      have;
        logic [MAX_VERTICES-1:0] live;
        logic [MAX_VERTICES-1:0] visited;
        logic [MAX_VERTICES-1:0] frontier;
        expansion_t              next_step;
        n = (vertex_count_q == 0) ? 1 :
            (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_q);
        live = MAX_VERTICES'((32'd1 << n) - 1);
        visited = '0;
        frontier = MAX_VERTICES'(1);
        count = 0;
        while (frontier != 0 && count < n)
        begin
            have = 0;
            best = 0;
            // pick the least heuristic, lower index wins ties
            for (int i = 0; i < n; i++)
            begin
                if (frontier[i] && (!have || heuristics[i] < heuristics[best]))
                begin
                    best = i;
                    have = 1;
                end
            end
            if (!have)
                break;
            visited[best] = 1'b1;
            frontier = (frontier | (adjacency[best] & live)) & ~visited;
            next_step.vertex = best[VIDX_W-1:0];
            next_step.found  = (best == int'(target_q));
            next_step.last   = next_step.found || frontier == 0;
            expected_steps.insert(expected_steps.size(), next_step);
            count++;
            if (next_step.found)
                break;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adjacency[i]  = '0;
                heuristics[i] = '0;
            end
            vertex_count_q = VCOUNT_W'(16);
            target_q       = '0;
            expected_steps.delete();
            mismatch_count = 0;
            steps_pending  = 0;
            steps_checked  = 0;
        end
        else
        begin
            // compare each expansion with the oldest one predicted
            if (result_valid)
            begin
                got_step.vertex = expanded_vertex;
                got_step.last   = last_flag;
                got_step.found  = target_found;
                if (expected_steps.size() == 0)
                    report_mismatch("expansion with none pending, vertex", -1,
                                    int'(got_step.vertex));
                else
                begin
                    want_step = expected_steps.pop_front();
                    if (got_step.vertex !== want_step.vertex)
                        report_mismatch("expanded_vertex", int'(want_step.vertex),
                                        int'(got_step.vertex));
                    if (got_step.last !== want_step.last)
                        report_mismatch("last_flag", int'(want_step.last),
                                        int'(got_step.last));
                    if (got_step.found !== want_step.found)
                        report_mismatch("target_found", int'(want_step.found),
                                        int'(got_step.found));
                end
                steps_checked++;
            end

            // track register writes
            if (cfg_write)
            begin
                if (cfg_index == CFG_VERTEX_COUNT)
                    vertex_count_q = cfg_data;
                else if (cfg_index == CFG_TARGET_VERTEX)
                    target_q = cfg_data[VIDX_W-1:0];
            end

            // apply each accepted request
            if (start && !busy)
            begin
                case (kind)
                    KIND_SET_EDGE:
                    begin
                        if (edge_cost == NO_EDGE_COST)
                        begin
                            adjacency[first_vertex][second_vertex] = 1'b0;
                            adjacency[second_vertex][first_vertex] = 1'b0;
                        end
                        else
                        begin
                            adjacency[first_vertex][second_vertex] = 1'b1;
                            adjacency[second_vertex][first_vertex] = 1'b1;
                        end
                    end
                    KIND_SET_HEUR: heuristics[first_vertex] = heuristic_value;
                    KIND_RUN:      search_expansions();
                    default:       ;
                endcase
            end
            steps_pending = expected_steps.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
module tb;
    import gbfs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 25;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [KIND_W-1:0]      kind;
    logic [VIDX_W-1:0]      first_vertex;
    logic [VIDX_W-1:0]      second_vertex;
    logic [COST_W-1:0]      edge_cost;
    logic [HEUR_W-1:0]      heuristic_value;
    logic                   result_valid;
    logic [VIDX_W-1:0]      expanded_vertex;
    logic                   last_flag;
    logic                   target_found;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int steps_pending;
    int steps_checked;
    int requests_sent;
    int searches_sent;
    int idle_pct;
    int quiet_cycles;

    greedy_best_first_search dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .first_vertex    (first_vertex),
        .second_vertex   (second_vertex),
        .edge_cost       (edge_cost),
        .heuristic_value (heuristic_value),
        .result_valid    (result_valid),
        .expanded_vertex (expanded_vertex),
        .last_flag       (last_flag),
        .target_found    (target_found),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    gbfs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .first_vertex    (first_vertex),
        .second_vertex   (second_vertex),
        .edge_cost       (edge_cost),
        .heuristic_value (heuristic_value),
        .result_valid    (result_valid),
        .expanded_vertex (expanded_vertex),
        .last_flag       (last_flag),
        .target_found    (target_found),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .steps_pending   (steps_pending),
        .steps_checked   (steps_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // End the run when nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_write || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Hold a request until the block takes it, then maybe idle
    task automatic send_request(input logic [KIND_W-1:0] k, input logic [VIDX_W-1:0] a,
                                input logic [VIDX_W-1:0] b, input logic [COST_W-1:0] c,
                                input logic [HEUR_W-1:0] h);
        kind            = k;
        first_vertex    = a;
        second_vertex   = b;
        edge_cost       = c;
        heuristic_value = h;
        start           = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        requests_sent++;
        if (k == KIND_RUN)
            searches_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Drop start and wait until every predicted expansion has arrived
    task automatic settle();
        start = 1'b0;
        while (steps_pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_index = idx;
        cfg_data  = data;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Mostly a vertex in use, sometimes any vertex
    function automatic logic [VIDX_W-1:0] pick_vertex(input int n);
        if ($urandom_range(99) < 85)
            return VIDX_W'($urandom_range(0, n - 1));
        return VIDX_W'($urandom_range(0, MAX_VERTICES - 1));
    endfunction

    initial
    begin
        int vc;
        int n_use;
        int tgt;
        int calm_phase;
        int roll;
        logic [COST_W-1:0] cost;
        logic [HEUR_W-1:0] heur;

        rst_n           = 1'b0;
        start           = 1'b0;
        kind            = KIND_SET_EDGE;
        first_vertex    = '0;
        second_vertex   = '0;
        edge_cost       = '0;
        heuristic_value = '0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_VERTEX_COUNT;
        cfg_data        = '0;
        requests_sent   = 0;
        searches_sent   = 0;
        idle_pct        = 30;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty graph, extremes of costs and heuristics, odd kinds
        write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(16));
        write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(15));
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);
        send_request(KIND_SET_HEUR, 4'd0, 4'd0, 10'd0, 16'hFFFF);
        send_request(KIND_SET_HEUR, 4'd15, 4'd0, 10'd0, 16'd0);
        send_request(KIND_SET_HEUR, 4'd5, 4'd0, 10'd0, 16'd0);
        send_request(KIND_SET_EDGE, 4'd0, 4'd5, 10'd0, 16'd0);
        send_request(KIND_SET_EDGE, 4'd5, 4'd15, 10'd1023, 16'd0);
        send_request(KIND_SET_EDGE, 4'd0, 4'd15, 10'd998, 16'd0);
        send_request(KIND_SET_EDGE, 4'd3, 4'd3, 10'd500, 16'd0);
        send_request(KIND_SET_EDGE, 4'd0, 4'd7, NO_EDGE_COST, 16'd0);
        send_request(KIND_UNUSED, 4'd15, 4'd15, 10'd1023, 16'hFFFF);
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);
        send_request(KIND_SET_EDGE, 4'd15, 4'd0, NO_EDGE_COST, 16'd0);
        send_request(KIND_SET_HEUR, 4'd9, 4'd0, 10'd0, 16'd0);
        send_request(KIND_SET_EDGE, 4'd5, 4'd9, 10'd1, 16'd0);
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);

        // Directed: vertices beyond the count, and count extremes
        write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(10));
        write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(9));
        send_request(KIND_SET_EDGE, 4'd9, 4'd12, 10'd2, 16'd0);
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);
        write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(1));
        write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(0));
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);
        write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(0));
        write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(15));
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);
        write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(31));
        write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(12));
        send_request(KIND_RUN, 4'd0, 4'd0, 10'd0, 16'd0);

        // Random: one configuration per phase, one phase without idling
        calm_phase = $urandom_range(4, NUM_PHASES - 1);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       vc = 16;
                1:       vc = $urandom_range(2, 15);
                2:       vc = 1;
                3:       vc = $urandom_range(17, 31);
                default: vc = $urandom_range(2, 16);
            endcase
            n_use = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
            if ($urandom_range(99) < 75)
                tgt = $urandom_range(0, n_use - 1);
            else
                tgt = $urandom_range(0, MAX_VERTICES - 1);
            write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
            write_register(CFG_TARGET_VERTEX, CFG_DATA_W'(tgt));
            idle_pct = (p == calm_phase) ? 0 : 30;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                if ($urandom_range(99) < 20)
                    cost = NO_EDGE_COST;
                else if ($urandom_range(99) < 12)
                    cost = COST_W'($urandom_range(1000, 1023));
                else
                    cost = COST_W'($urandom_range(0, 998));
                if ($urandom_range(99) < 40)
                    heur = HEUR_W'($urandom_range(0, 3));
                else if ($urandom_range(99) < 15)
                    heur = 16'hFFFF;
                else
                    heur = HEUR_W'($urandom_range(0, 65535));
                if (roll < 45)
                    send_request(KIND_SET_EDGE, pick_vertex(n_use), pick_vertex(n_use),
                                 cost, heur);
                else if (roll < 72)
                    send_request(KIND_SET_HEUR, pick_vertex(n_use), pick_vertex(n_use),
                                 cost, heur);
                else if (roll < 95)
                    send_request(KIND_RUN, pick_vertex(n_use), pick_vertex(n_use),
                                 cost, heur);
                else
                    send_request(KIND_UNUSED, pick_vertex(n_use), pick_vertex(n_use),
                                 cost, heur);
            end
        end

        // Drain and give the verdict
        settle();
        repeat (20) @(negedge clk);
        $display("Covered %0d requests, %0d of them searches, over %0d random settings",
                 requests_sent, searches_sent, NUM_PHASES);
        $display("Checked %0d expansions against the prediction", steps_checked);
        if (mismatch_count == 0 && steps_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: greedy_best_first_search.f
hw/rtl/gbfs_pkg.sv
hw/rtl/gbfs_scan.sv
hw/rtl/greedy_best_first_search.sv
tb/sv/gbfs_checker.sv
tb/sv/tb.sv
